// File: rtl/core/llat_pkg.sv
// llat_pkg: shared types and constants of the link loss alert table.
// Used by llat_ctrl, llat_dpath and link_loss_alert_table; no dependencies.
`default_nettype none

package llat_pkg;

   // Operation codes carried on req_tuser
   localparam logic [1:0] OP_TX  = 2'd0;
   localparam logic [1:0] OP_RX  = 2'd1;
   localparam logic [1:0] OP_DEL = 2'd2;

   // Field widths
   localparam int OP_W       = 2;
   localparam int ADDR_W     = 32;
   localparam int LOST_W     = 16;
   localparam int THRESH_W   = 8;
   localparam int SUSP_W     = 8;
   localparam int REQ_DATA_W = 56;   // address, packet valid, lost count, padded to bytes
   localparam int RSP_DATA_W = 48;   // alert, alert address, table full, count, padded

   // Configuration port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic REG_MONITOR   = 1'b0;   // byte address 0
   localparam logic REG_THRESHOLD = 1'b1;   // byte address 4
   localparam logic                MONITOR_RST   = 1'b1;
   localparam logic [THRESH_W-1:0] THRESHOLD_RST = 8'd3;

   // Sequencing commands from the controller to the datapath
   typedef struct packed {
      logic load;     // capture an accepted request
      logic lookup;   // compare key against every entry
      logic select;   // pick the entry, read its count
      logic commit;   // update the table and load the result register
   } cmd_type;

endpackage

`default_nettype wire

// File: rtl/core/link_loss_alert_table.sv
// link_loss_alert_table: per-connection suspicion counters keyed by access address.
//
// Requests enter on req_* (tvalid/tready). req_tuser carries the operation
// (transmit, receive, connection delete); req_tdata carries the access
// address, packet valid flag and lost packet count. Every request yields
// exactly one result on rsp_*: alert flag, alert address, table full flag
// and the entry's suspicion count.
// A request passes lookup, select with count memory read, and update before
// its result is registered. One request is handled at a time, so a new request
// is taken only once the previous one has left update; the count memory
// read-modify-write is the reason. A held result does not block acceptance of the next
// request; only the update of the following one waits for rsp_tready.
// Reset empties the table, sets monitoring on and the threshold to 3.
// The csr_* port is APB style: monitor enable at 0x0, alert threshold at 0x4.
// Write configuration only while no request is in flight.
// Depends on llat_pkg, llat_ctrl, llat_dpath.
`default_nettype none

module link_loss_alert_table
   import llat_pkg::*;
#(
   parameter int TABLE_ENTRIES = 16,
   parameter int COUNT_BITS    = 8
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   // request channel
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [REQ_DATA_W-1:0]  req_tdata,   // [31:0] link address, [32] packet_valid,
                                                    // [48:33] lost_count, rest zero
   input  wire logic [OP_W-1:0]        req_tuser,   // [1:0] operation
   // result channel
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [RSP_DATA_W-1:0]       rsp_tdata,   // [0] alert, [32:1] alert_address,
                                                    // [33] table_full, [41:34] suspicion_count
   // configuration port
   input  wire logic                   csr_psel,
   input  wire logic                   csr_penable,
   input  wire logic                   csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0]  csr_paddr,
   input  wire logic [CSR_DATA_W-1:0]  csr_pwdata,
   output logic [CSR_DATA_W-1:0]       csr_prdata,
   output logic                        csr_pready
);

   cmd_type             cmd;
   logic                monitor_ff, monitor_in;
   logic [THRESH_W-1:0] threshold_ff, threshold_in;
   logic                csr_wr;
   logic                csr_idx;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_idx    = csr_paddr[2];

   // Configuration registers
   always_comb begin
      monitor_in   = monitor_ff;
      threshold_in = threshold_ff;
      if (csr_wr) begin
         case (csr_idx)
            REG_MONITOR:   monitor_in   = csr_pwdata[0];
            REG_THRESHOLD: threshold_in = csr_pwdata[THRESH_W-1:0];
            default:       monitor_in   = monitor_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         monitor_ff   <= MONITOR_RST;
         threshold_ff <= THRESHOLD_RST;
      end else begin
         monitor_ff   <= monitor_in;
         threshold_ff <= threshold_in;
      end
   end

   // Register read-back
   always_comb begin
      case (csr_idx)
         REG_MONITOR:   csr_prdata = {{(CSR_DATA_W-1){1'b0}}, monitor_ff};
         REG_THRESHOLD: csr_prdata = {{(CSR_DATA_W-THRESH_W){1'b0}}, threshold_ff};
         default:       csr_prdata = '0;
      endcase
   end

   llat_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   llat_dpath #(
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .COUNT_BITS    (COUNT_BITS)
   ) u_dpath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .req_operation      (req_tuser),
      .req_link_addr      (req_tdata[ADDR_W-1:0]),
      .req_packet_valid   (req_tdata[ADDR_W]),
      .req_lost_count     (req_tdata[ADDR_W+LOST_W:ADDR_W+1]),
      .monitor_enabled    (monitor_ff),
      .alert_threshold    (threshold_ff),
      .rsp_data           (rsp_tdata)
   );

endmodule

`default_nettype wire

// File: rtl/core/llat_ctrl.sv
// llat_ctrl: request sequencer of the link loss alert table.
// Depends on llat_pkg; drives the datapath through a cmd_type bundle.
`default_nettype none

module llat_ctrl
   import llat_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_tvalid,
   output logic         req_tready,
   output logic         rsp_tvalid,
   input  wire logic    rsp_tready,
   output cmd_type      cmd
);

   typedef enum logic [1:0] {ST_IDLE, ST_LOOKUP, ST_SELECT, ST_UPDATE} state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   // The result register can take a new result when empty or being drained
   assign slot_free = !rsp_valid_ff || rsp_tready;

   // Command decode
   always_comb begin
      cmd        = '0;
      cmd.load   = (state_ff == ST_IDLE) && req_tvalid;
      cmd.lookup = (state_ff == ST_LOOKUP);
      cmd.select = (state_ff == ST_SELECT);
      cmd.commit = (state_ff == ST_UPDATE) && slot_free;
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (req_tvalid) state_in = ST_LOOKUP;
         ST_LOOKUP: state_in = ST_SELECT;
         ST_SELECT: state_in = ST_UPDATE;
         ST_UPDATE: if (slot_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // Result valid flag
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   // An accepted request walks lookup, select, update in fixed order
   a_load_then_lookup: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> cmd.lookup)
      else $error("request not followed by lookup");

   a_load_reaches_update: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> ##3 (state_ff == ST_UPDATE))
      else $error("request did not reach update");

endmodule

`default_nettype wire

// File: rtl/core/llat_dpath.sv
// llat_dpath: key table, count memory and result register of the alert table.
// Depends on llat_pkg; sequenced by llat_ctrl through cmd_type.
`default_nettype none

module llat_dpath
   import llat_pkg::*;
#(
   parameter int TABLE_ENTRIES = 16,
   parameter int COUNT_BITS    = 8
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire cmd_type               cmd,
   input  wire logic [OP_W-1:0]       req_operation,
   input  wire logic [ADDR_W-1:0]     req_link_addr,
   input  wire logic                  req_packet_valid,
   input  wire logic [LOST_W-1:0]     req_lost_count,
   input  wire logic                  monitor_enabled,
   input  wire logic [THRESH_W-1:0]   alert_threshold,
   output logic [RSP_DATA_W-1:0]      rsp_data
);

   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CMP_W = (COUNT_BITS > SUSP_W) ? COUNT_BITS : SUSP_W;
   localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

   // Lowest set bit of a per-entry vector
   function automatic logic [IDX_W-1:0] first_set(input logic [TABLE_ENTRIES-1:0] v);
      logic [IDX_W-1:0] r;
      r = '0;
      for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
         if (v[i]) r = IDX_W'(i);
      end
      return r;
   endfunction

   // Captured request
   logic [OP_W-1:0]    op_ff;
   logic [ADDR_W-1:0]  addr_ff;
   logic               pvalid_ff;
   logic               lost_ff;

   // Table state
   logic [TABLE_ENTRIES-1:0] used_ff;
   logic [ADDR_W-1:0]        key_ff [TABLE_ENTRIES];
   logic [COUNT_BITS-1:0]    cnt_mem [TABLE_ENTRIES];

   // Lookup and select stages
   logic [TABLE_ENTRIES-1:0] match_ff, free_ff;
   logic                     hit_ff, room_ff;
   logic [IDX_W-1:0]         idx_ff;
   logic [COUNT_BITS-1:0]    cnt_rd_ff;

   // Result register
   logic                alert_ff, full_ff;
   logic [ADDR_W-1:0]   alert_addr_ff;
   logic [SUSP_W-1:0]   susp_ff;

   // Commit stage signals
   logic                  is_track, is_del, alloc, full, upd, bump, clr, alert;
   logic [COUNT_BITS-1:0] cnt_base, cnt_inc, cnt_new;
   logic [CMP_W-1:0]      cnt_inc_ext, cnt_new_ext, thr_ext;
   logic [SUSP_W-1:0]     susp;

   // Request capture
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff     <= req_operation;
         addr_ff   <= req_link_addr;
         pvalid_ff <= req_packet_valid;
         lost_ff   <= |req_lost_count;
      end
   end

   // Key compare against every entry, then pick entry and read its count
   always_ff @(posedge clock) begin
      if (cmd.lookup) begin
         for (int i = 0; i < TABLE_ENTRIES; i++) begin
            match_ff[i] <= used_ff[i] && (key_ff[i] == addr_ff);
         end
         free_ff <= ~used_ff;
      end
      if (cmd.select) begin
         hit_ff    <= |match_ff;
         room_ff   <= |free_ff;
         idx_ff    <= (|match_ff) ? first_set(match_ff) : first_set(free_ff);
         cnt_rd_ff <= cnt_mem[first_set(match_ff)];
      end
   end

   // Event evaluation
   always_comb begin
      is_track = ((op_ff == OP_TX) || (op_ff == OP_RX)) && monitor_enabled;
      is_del   = (op_ff == OP_DEL);
      alloc    = is_track && !hit_ff && room_ff;
      full     = is_track && !hit_ff && !room_ff;
      upd      = is_track && (hit_ff || room_ff);
      cnt_base = hit_ff ? cnt_rd_ff : '0;
      bump     = ((op_ff == OP_RX) && !pvalid_ff) || lost_ff;
      clr      = (op_ff == OP_RX) && pvalid_ff && !lost_ff;
      cnt_inc  = (bump && (cnt_base != CNT_MAX)) ? cnt_base + COUNT_BITS'(1) : cnt_base;
      cnt_new  = clr ? '0 : cnt_inc;
      cnt_inc_ext = CMP_W'(cnt_inc);
      cnt_new_ext = CMP_W'(cnt_new);
      thr_ext     = CMP_W'(alert_threshold);
      // alert is tested before a valid receive clears the count
      alert = upd && (cnt_inc_ext > thr_ext);
      if (!upd) begin
         susp = '0;
      end else if (|(cnt_new_ext >> SUSP_W)) begin
         susp = {SUSP_W{1'b1}};
      end else begin
         susp = cnt_new_ext[SUSP_W-1:0];
      end
   end

   // Entry occupancy
   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
      end else if (cmd.commit) begin
         if (is_del && hit_ff) begin
            used_ff[idx_ff] <= 1'b0;
         end else if (alloc) begin
            used_ff[idx_ff] <= 1'b1;
         end
      end
   end

   // Keys and counts
   always_ff @(posedge clock) begin
      if (cmd.commit && alloc) begin
         key_ff[idx_ff] <= addr_ff;
      end
      if (cmd.commit && upd) begin
         cnt_mem[idx_ff] <= cnt_new;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         alert_ff      <= alert;
         alert_addr_ff <= alert ? addr_ff : '0;
         full_ff       <= full;
         susp_ff       <= susp;
      end
   end

   assign rsp_data = {6'b0, susp_ff, full_ff, alert_addr_ff, alert_ff};

   // A key is never held by two entries
   a_unique_key: assert property (@(posedge clock) disable iff (reset)
      cmd.select |-> $onehot0(match_ff))
      else $error("access address held by more than one entry");

   // An allocation marks its entry in use
   a_alloc_marks_used: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && alloc) |=> used_ff[$past(idx_ff)])
      else $error("allocated entry not marked in use");

endmodule

`default_nettype wire
